FILE: design/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants for the RC channel frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int NUM_CHANNELS_DEF = 14;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 5;
  localparam int CSUM_W   = 16;
  localparam int VALUE_W  = 12;
  localparam int CH_IDX_W = 4;

  localparam logic [BYTE_W-1:0]  SYNC_FIRST  = 8'h20;
  localparam logic [BYTE_W-1:0]  SYNC_SECOND = 8'h40;
  localparam logic [CSUM_W-1:0]  CSUM_SEED   = 16'hff9f;
  localparam logic [CSUM_W-1:0]  VALUE_MASK  = 16'h0fff;

  typedef enum logic {
    ST_RECV,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;
    logic emit_start;
    logic emit_next;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_ok;   // current byte closes a frame with a matching checksum
    logic emit_last;  // emit pointer sits on the final channel
  } sts_t;

endpackage

FILE: design/rc_channel_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// rc_channel_frame_decoder_core
// Decodes a sync-framed RC channel stream one byte at a time and reports
// every channel of a frame whose checksum matches.
// ----------------------------------------------------------------------------
//  channel  | ports                                      | dir
//  ---------+--------------------------------------------+----
//  in       | in_valid, in_ready, in_rx_byte[7:0]        | in
//  out      | out_valid, out_ready, out_channel_index[3:0],
//           | out_channel_value[11:0], out_last_of_frame | out
//
//  One byte is taken per cycle while receiving; the datapath updates
//  position, checksum and channel store in that same cycle.
//  A byte that closes a good frame is followed by one result per channel
//  (read from the store at the readout pointer); in_ready is low during
//  that readout, and out_ready low stretches it.
//  Reset (rst_n low, synchronous) returns the decoder to waiting for sync.
// ----------------------------------------------------------------------------
module rc_channel_frame_decoder_core #(
  parameter int NUM_CHANNELS = rcfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rcfd_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rcfd_pkg::CH_IDX_W-1:0] out_channel_index,
  output logic [rcfd_pkg::VALUE_W-1:0]  out_channel_value,
  output logic                          out_last_of_frame
);

  rcfd_pkg::cmd_t cmd;
  rcfd_pkg::sts_t sts;

  rcfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rcfd_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .rx_byte       (in_rx_byte),
    .channel_index (out_channel_index),
    .channel_value (out_channel_value),
    .last_of_frame (out_last_of_frame)
  );

`ifndef SYNTHESIS
  // no byte is taken while a frame is being read out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during readout");

  // readout starts at channel zero
  a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready ##1 out_valid) |-> (out_channel_index == '0))
    else $error("readout does not start at channel zero");

  // readout steps one channel per accepted request
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_frame) |=>
      (out_valid && (out_channel_index == $past(out_channel_index) + 1'b1)))
    else $error("channel index did not advance");

  // decoder returns to receiving after the final channel
  a_back_to_recv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_of_frame) |=> (in_ready && !out_valid))
    else $error("decoder stuck after final channel");
`endif

endmodule

FILE: design/rcfd_ctrl.sv
// ----------------------------------------------------------------------------
// rcfd_ctrl
// Controller: takes bytes while receiving, then walks the channel readout.
// ----------------------------------------------------------------------------
module rcfd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rcfd_pkg::sts_t sts,
  output rcfd_pkg::cmd_t cmd
);

  rcfd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcfd_pkg::ST_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd.take_byte  = 1'b0;
    cmd.emit_start = 1'b0;
    cmd.emit_next  = 1'b0;
    case (state_r)
      rcfd_pkg::ST_RECV: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
        if (in_valid && sts.frame_ok) begin
          cmd.emit_start = 1'b1;
          state_nxt      = rcfd_pkg::ST_EMIT;
        end
      end
      rcfd_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.emit_last) begin
            state_nxt = rcfd_pkg::ST_RECV;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = rcfd_pkg::ST_RECV;
      end
    endcase
  end

endmodule

FILE: design/rcfd_datapath.sv
// ----------------------------------------------------------------------------
// rcfd_datapath
// Byte history, frame position, running checksum, channel store, readout.
// ----------------------------------------------------------------------------
module rcfd_datapath #(
  parameter int NUM_CHANNELS = rcfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rcfd_pkg::cmd_t                  cmd,
  output rcfd_pkg::sts_t                  sts,
  input  logic [rcfd_pkg::BYTE_W-1:0]     rx_byte,
  output logic [rcfd_pkg::CH_IDX_W-1:0]   channel_index,
  output logic [rcfd_pkg::VALUE_W-1:0]    channel_value,
  output logic                            last_of_frame
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [rcfd_pkg::POS_W-1:0] FRAME_END =
    rcfd_pkg::POS_W'(2 * NUM_CHANNELS + 2);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  logic [rcfd_pkg::BYTE_W-1:0]  prev_r;
  logic [rcfd_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [rcfd_pkg::CSUM_W-1:0]  csum_r, csum_nxt;
  logic [IDX_W-1:0]             idx_r;
  logic [rcfd_pkg::VALUE_W-1:0] store [NUM_CHANNELS];
  logic [rcfd_pkg::VALUE_W-1:0] value_r;

  logic                          sync_hit;
  logic                          in_frame;
  logic [rcfd_pkg::POS_W-1:0]    pos_inc;
  logic [rcfd_pkg::CSUM_W-1:0]   word;
  logic [rcfd_pkg::BYTE_W:0]     pair_sum;
  logic [rcfd_pkg::CH_IDX_W-1:0] slot;
  logic                          store_we;

  assign sync_hit = (prev_r == rcfd_pkg::SYNC_FIRST) && (rx_byte == rcfd_pkg::SYNC_SECOND);
  assign in_frame = (pos_r < FRAME_END);
  assign pos_inc  = pos_r + 1'b1;
  assign word     = {rx_byte, prev_r};
  assign pair_sum = {1'b0, prev_r} + {1'b0, rx_byte};
  // word k lands when the position reaches 2k+2
  assign slot     = pos_inc[rcfd_pkg::POS_W-1:1] - 1'b1;

  assign sts.frame_ok  = !sync_hit && in_frame && (pos_inc == FRAME_END) && (word == csum_r);
  assign sts.emit_last = (idx_r == LAST_IDX);

  always_comb begin
    pos_nxt  = pos_r;
    csum_nxt = csum_r;
    store_we = 1'b0;
    if (cmd.take_byte) begin
      if (sync_hit) begin
        pos_nxt  = '0;
        csum_nxt = rcfd_pkg::CSUM_SEED;
      end else if (in_frame) begin
        pos_nxt = pos_inc;
        if (!pos_inc[0] && (pos_inc != FRAME_END)) begin
          store_we = 1'b1;
          csum_nxt = csum_r - rcfd_pkg::CSUM_W'(pair_sum);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      pos_r  <= FRAME_END;
      csum_r <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.take_byte) begin
        prev_r <= rx_byte;
      end
      pos_r  <= pos_nxt;
      csum_r <= csum_nxt;
      if (cmd.emit_start) begin
        idx_r <= '0;
      end else if (cmd.emit_next) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // readout data is fetched at the edge that moves the pointer
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[slot[IDX_W-1:0]] <= rcfd_pkg::VALUE_W'(word & rcfd_pkg::VALUE_MASK);
    end
    if (cmd.emit_start) begin
      value_r <= store['0];
    end else if (cmd.emit_next) begin
      value_r <= store[idx_r + 1'b1];
    end
  end

  assign channel_index = rcfd_pkg::CH_IDX_W'(idx_r);
  assign channel_value = value_r;
  assign last_of_frame = sts.emit_last;

endmodule

FILE: tb/rcfd_checker.sv
// ----------------------------------------------------------------------------
// rcfd_checker
// Watches both channels of the RC frame decoder, tracks sync, position,
// checksum and stored channels for every accepted byte, and compares each
// reported channel with the oldest predicted one.
// ----------------------------------------------------------------------------
module rcfd_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [rcfd_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [rcfd_pkg::CH_IDX_W-1:0] out_channel_index,
  input  logic [rcfd_pkg::VALUE_W-1:0]  out_channel_value,
  input  logic                          out_last_of_frame,
  output int                            pending_reports,
  output int                            fail_count
);

  localparam int FRAME_END = 2 * rcfd_pkg::NUM_CHANNELS_DEF + 2;

  typedef struct packed {
    logic [rcfd_pkg::CH_IDX_W-1:0] index;
    logic [rcfd_pkg::VALUE_W-1:0]  value;
    logic                          last;
  } chan_report_t;

  chan_report_t                 expected_reports[$];
  logic [rcfd_pkg::BYTE_W-1:0]  last_byte;
  logic [rcfd_pkg::POS_W-1:0]   frame_pos;
  logic [rcfd_pkg::CSUM_W-1:0]  frame_sum;
  logic [rcfd_pkg::VALUE_W-1:0] channel_copy [rcfd_pkg::NUM_CHANNELS_DEF];
  int                           fails = 0;

  initial begin
    pending_reports = 0;
    fail_count = 0;
  end

  task automatic absorb_byte(input logic [rcfd_pkg::BYTE_W-1:0] rx);
    logic [rcfd_pkg::BYTE_W-1:0] older;
    logic [rcfd_pkg::CSUM_W-1:0] word;
    chan_report_t                rep;
    int                          k;
    older = last_byte;
    last_byte = rx;
    // sync pair wins over everything, even mid-frame
    if (older == rcfd_pkg::SYNC_FIRST && rx == rcfd_pkg::SYNC_SECOND) begin
      frame_pos = '0;
      frame_sum = rcfd_pkg::CSUM_SEED;
    end else if (frame_pos < FRAME_END) begin
      frame_pos = frame_pos + 1'b1;
      if (!frame_pos[0]) begin
        word = {rx, older};
        if (frame_pos == FRAME_END) begin
          if (word == frame_sum) begin
            for (k = 0; k < rcfd_pkg::NUM_CHANNELS_DEF; k++) begin
              rep.index = rcfd_pkg::CH_IDX_W'(k);
              rep.value = channel_copy[k];
              rep.last  = (k == rcfd_pkg::NUM_CHANNELS_DEF - 1);
              expected_reports.push_back(rep);
            end
          end
        end else begin
          channel_copy[frame_pos / 2 - 1] = word[rcfd_pkg::VALUE_W-1:0];
          frame_sum = frame_sum - (rcfd_pkg::CSUM_W'(older) + rcfd_pkg::CSUM_W'(rx));
        end
      end
    end
  endtask

  task automatic check_report();
    chan_report_t want;
    if (expected_reports.size() == 0) begin
      $error("unexpected channel report: index %0d value %0d last %0b",
             out_channel_index, out_channel_value, out_last_of_frame);
      fails++;
    end else begin
      want = expected_reports.pop_front();
      if (out_channel_index !== want.index) begin
        $error("channel_index: expected %0d, got %0d", want.index, out_channel_index);
        fails++;
      end
      if (out_channel_value !== want.value) begin
        $error("channel_value: expected %0d, got %0d", want.value, out_channel_value);
        fails++;
      end
      if (out_last_of_frame !== want.last) begin
        $error("last_of_frame: expected %0b, got %0b", want.last, out_last_of_frame);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      last_byte = '0;
      frame_pos = rcfd_pkg::POS_W'(FRAME_END);
      frame_sum = '0;
      foreach (channel_copy[k]) channel_copy[k] = '0;
      expected_reports.delete();
    end else begin
      if (in_valid && in_ready) absorb_byte(in_rx_byte);
      if (out_valid && out_ready) check_report();
    end
    pending_reports <= expected_reports.size();
    fail_count <= fails;
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the RC frame decoder with idle noise, good frames, frames with a
// bad checksum, cut frames and syncs inside data, in random bursts against a
// receiver that stalls on its own cadence; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_BYTES = 230;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_CADENCE,
    RX_CHOKE
  } rx_mode_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [rcfd_pkg::BYTE_W-1:0]   in_rx_byte;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [rcfd_pkg::CH_IDX_W-1:0] out_channel_index;
  logic [rcfd_pkg::VALUE_W-1:0]  out_channel_value;
  logic                          out_last_of_frame;

  int pending_reports;
  int fail_count;

  logic [15:0] frame_words [rcfd_pkg::NUM_CHANNELS_DEF];
  int          burst_left = 0;
  int          bytes_sent = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  logic [7:0]  rx_tick = '0;

  rc_channel_frame_decoder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel_index(out_channel_index),
    .out_channel_value(out_channel_value),
    .out_last_of_frame(out_last_of_frame)
  );

  rcfd_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel_index(out_channel_index),
    .out_channel_value(out_channel_value),
    .out_last_of_frame(out_last_of_frame),
    .pending_reports  (pending_reports),
    .fail_count       (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stall cadence, switched each time the 8-bit tick counter wraps
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_tick == '0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
      RX_CADENCE: out_ready <= (rx_tick[1:0] != 2'b11);
      default:    out_ready <= (rx_tick % 6 == 0);
    endcase
  end

  task automatic put_byte(input logic [rcfd_pkg::BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 24);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_sent++;
  endtask

  // hold off requests until every predicted channel has been reported
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
  endtask

  // sync, then the first words_kept words; a full frame also gets its checksum
  task automatic send_frame(input bit corrupt, input int words_kept);
    logic [rcfd_pkg::CSUM_W-1:0] sum;
    int k;
    sum = rcfd_pkg::CSUM_SEED;
    put_byte(rcfd_pkg::SYNC_FIRST);
    put_byte(rcfd_pkg::SYNC_SECOND);
    for (k = 0; k < words_kept; k++) begin
      put_byte(frame_words[k][7:0]);
      put_byte(frame_words[k][15:8]);
      sum = sum - (rcfd_pkg::CSUM_W'(frame_words[k][7:0])
                   + rcfd_pkg::CSUM_W'(frame_words[k][15:8]));
    end
    if (words_kept == rcfd_pkg::NUM_CHANNELS_DEF) begin
      if (corrupt) sum = sum ^ rcfd_pkg::CSUM_W'($urandom_range(1, 16'hffff));
      put_byte(sum[7:0]);
      put_byte(sum[15:8]);
    end
  endtask

  task automatic fill_random_words();
    int k;
    int flavor;
    flavor = $urandom_range(0, 2);
    for (k = 0; k < rcfd_pkg::NUM_CHANNELS_DEF; k++) begin
      case (flavor)
        0:       frame_words[k] = 16'($urandom_range(0, 16'hffff));
        1:       frame_words[k] = 16'($urandom_range(0, 16'h0fff));
        default: frame_words[k] = 16'($urandom_range(988, 2012));
      endcase
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) put_byte(rcfd_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  initial begin
    int stop_at;
    int pick;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // idle bytes, including lone sync halves
    put_byte(rcfd_pkg::SYNC_SECOND);
    put_byte(rcfd_pkg::SYNC_FIRST);
    put_byte(8'h00);
    put_byte(8'hff);

    // full good frame with extreme words
    frame_words = '{16'h0000, 16'hffff, 16'h0fff, 16'hf000, 16'h0001, 16'h8000,
                    16'h00ff, 16'hff00, 16'h0800, 16'h7fff, 16'h1234, 16'hfffe,
                    16'h0ffe, 16'h5aa5};
    send_frame(1'b0, rcfd_pkg::NUM_CHANNELS_DEF);
    drain_reports();

    // bad checksum, then a sync landing where the fourth word would be
    send_frame(1'b1, rcfd_pkg::NUM_CHANNELS_DEF);
    send_frame(1'b0, 3);
    send_frame(1'b0, rcfd_pkg::NUM_CHANNELS_DEF);

    // sync straddling a word boundary inside data
    frame_words[4] = 16'h2011;
    frame_words[5] = 16'h3340;
    send_frame(1'b0, rcfd_pkg::NUM_CHANNELS_DEF);
    put_byte(8'ha5);
    drain_reports();

    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      fill_random_words();
      if (pick < 60) begin
        send_frame(1'b0, rcfd_pkg::NUM_CHANNELS_DEF);
      end else if (pick < 72) begin
        send_frame(1'b1, rcfd_pkg::NUM_CHANNELS_DEF);
      end else if (pick < 84) begin
        send_frame(1'b0, $urandom_range(0, rcfd_pkg::NUM_CHANNELS_DEF - 1));
        send_noise($urandom_range(0, 3));
      end else if (pick < 92) begin
        send_noise($urandom_range(1, 6));
      end else begin
        send_frame(1'b0, rcfd_pkg::NUM_CHANNELS_DEF);
        drain_reports();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
